// ===== hdl/mq_pkg.sv =====
// shared types and constants for the cluster quality block
package mq_pkg;

  localparam int NODE_BITS    = 8;
  localparam int CLUSTER_BITS = 8;
  localparam int WEIGHT_BITS  = 16;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_BITS     = 34;
  localparam int QUAL_BITS    = 25;
  localparam int QUO_BITS     = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    OP_LABEL = 2'd0,
    OP_ADD   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // divider handshake toward the evaluate walk
  typedef struct packed {
    logic                  done;
    logic [QUO_BITS-1:0]   quo;
  } div_rsp_t;

endpackage

// ===== hdl/mq_div.sv =====
// restoring divider for one cluster term, one quotient bit per cycle
module mq_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mq_pkg::ACC_BITS:0]     num,
  input  logic [mq_pkg::ACC_BITS:0]     den,
  output mq_pkg::div_rsp_t              rsp
);

  localparam int CNT_BITS = $clog2(mq_pkg::QUO_BITS + 1);

  logic [mq_pkg::ACC_BITS+1:0] rem_r, rem_nxt;
  logic [mq_pkg::ACC_BITS:0]   den_r;
  logic [mq_pkg::QUO_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic                        ge;
  logic [mq_pkg::ACC_BITS+1:0] diff;

  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    diff     = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = {1'b0, num};
      quo_nxt = '0;
      cnt_nxt = CNT_BITS'(mq_pkg::QUO_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = {diff[mq_pkg::ACC_BITS:0], 1'b0};
      quo_nxt = {quo_r[mq_pkg::QUO_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (start) den_r <= den;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== hdl/mq_cluster_quality.sv =====
// cluster quality top level: label store, per-cluster accumulators and evaluate walk
// label word: accepted and written in the same cycle, next word taken the cycle after
// matrix word: label read, accumulator read, then write; a second write state when row and column
//   clusters differ, since the accumulator memories have a single write port
// evaluate word: a read and a data state per cluster, plus a divider run per cluster with intra weight
//   (17-step divider), then the result is loaded into the output register
// synchronous reset clears control and the accumulator valid bits; labels stay undefined
module mq_cluster_quality (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [mq_pkg::NODE_BITS-1:0]      in_row_node,
  input  logic [mq_pkg::NODE_BITS-1:0]      in_col_node,
  input  logic [mq_pkg::WEIGHT_BITS-1:0]    in_entry_weight,
  input  logic [8:0]                        in_cluster_label,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mq_pkg::QUAL_BITS-1:0]      out_quality
);

  localparam int CB = mq_pkg::CLUSTER_BITS;
  localparam int AB = mq_pkg::ACC_BITS;
  localparam int NCL = 1 << CB;
  localparam int NND = 1 << mq_pkg::NODE_BITS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LBL    = 8'b0000_0010,
    S_ACC    = 8'b0000_0100,
    S_WR2    = 8'b0000_1000,
    S_EV_RD  = 8'b0001_0000,
    S_EV_DAT = 8'b0010_0000,
    S_EV_DIV = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // memories: labels, intra sums and all sums
  logic [CB-1:0] label_mem [NND];
  logic [AB-1:0] intra_mem [NCL];
  logic [AB-1:0] all_mem   [NCL];

  state_t state_r, state_nxt;
  logic   acc_in;
  logic [CB-1:0] lab0_r, lab1_r;
  logic [CB-1:0] rc_r, rc_nxt, cc_r, cc_nxt;
  logic [AB-1:0] intra0_r, intra1_r, all0_r, all1_r;
  logic [CB-1:0] acc_addr0;
  logic          acc_we;
  logic [CB-1:0] acc_waddr;
  logic [AB-1:0] intra_wdata, all_wdata;
  logic [mq_pkg::WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [NCL-1:0] vld_r, vld_nxt;
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic [AB-1:0]  intra_cc_r, intra_cc_nxt, all_cc_r, all_cc_nxt;
  logic [mq_pkg::QUAL_BITS-1:0] total_r, total_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [mq_pkg::QUAL_BITS-1:0] out_quality_r, out_quality_nxt;

  // effective accumulator values, invalid entries read as zero
  logic [AB-1:0] i0_eff, i1_eff, a0_eff, a1_eff;
  logic [AB:0]   sum_ir, sum_ar, sum_ac;
  logic [AB-1:0] intra_rc_new, all_rc_new, all_cc_new;
  logic          same;

  // walk values of the cluster under evaluation
  logic [AB-1:0] walk_intra, walk_all;

  logic                 div_start;
  logic [AB:0]          div_num, div_den;
  mq_pkg::div_rsp_t     div_rsp;
  logic                 last;

  assign acc_in   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign last     = (cnt_r == CB'(NCL - 1));

  mq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp)
  );

  // saturating updates; a word inside one cluster adds twice to its all sum
  always_comb begin
    same   = (rc_r == cc_r);
    i0_eff = vld_r[rc_r] ? intra0_r : '0;
    i1_eff = vld_r[cc_r] ? intra1_r : '0;
    a0_eff = vld_r[rc_r] ? all0_r   : '0;
    a1_eff = vld_r[cc_r] ? all1_r   : '0;
    sum_ir = {1'b0, i0_eff} + (AB+1)'(w_r);
    sum_ar = {1'b0, a0_eff} + (AB+1)'(w_r) + (same ? (AB+1)'(w_r) : '0);
    sum_ac = {1'b0, a1_eff} + (AB+1)'(w_r);
    intra_rc_new = same ? (sum_ir[AB] ? '1 : sum_ir[AB-1:0]) : i0_eff;
    all_rc_new   = sum_ar[AB] ? '1 : sum_ar[AB-1:0];
    all_cc_new   = sum_ac[AB] ? '1 : sum_ac[AB-1:0];
  end

  // cluster term operands for the evaluate walk: 2*intra over max(all, 2*intra)
  always_comb begin
    walk_intra = vld_r[cnt_r] ? intra0_r : '0;
    walk_all   = vld_r[cnt_r] ? all0_r : '0;
    div_num    = {walk_intra, 1'b0};
    div_den    = ({1'b0, walk_all} > div_num) ? {1'b0, walk_all} : div_num;
  end

  always_comb begin
    state_nxt       = state_r;
    rc_nxt          = rc_r;
    cc_nxt          = cc_r;
    w_nxt           = w_r;
    vld_nxt         = vld_r;
    cnt_nxt         = cnt_r;
    intra_cc_nxt    = intra_cc_r;
    all_cc_nxt      = all_cc_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_quality_nxt = out_quality_r;
    acc_addr0       = (state_r == S_LBL) ? lab0_r : cnt_r;
    acc_we          = 1'b0;
    acc_waddr       = rc_r;
    intra_wdata     = intra_rc_new;
    all_wdata       = all_rc_new;
    div_start       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          w_nxt = in_entry_weight;
          case (mq_pkg::opcode_t'(in_opcode))
            mq_pkg::OP_ADD:  state_nxt = S_LBL;
            mq_pkg::OP_EVAL: begin
              cnt_nxt   = '0;
              total_nxt = '0;
              state_nxt = S_EV_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LBL: begin
        rc_nxt    = lab0_r;
        cc_nxt    = lab1_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_we       = 1'b1;
        vld_nxt[rc_r] = 1'b1;
        intra_cc_nxt = i1_eff;
        all_cc_nxt   = all_cc_new;
        state_nxt    = same ? S_IDLE : S_WR2;
      end
      S_WR2: begin
        acc_we        = 1'b1;
        acc_waddr     = cc_r;
        intra_wdata   = intra_cc_r;
        all_wdata     = all_cc_r;
        vld_nxt[cc_r] = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_EV_RD: state_nxt = S_EV_DAT;
      S_EV_DAT: begin
        if (walk_intra != '0) begin
          div_start = 1'b1;
          state_nxt = S_EV_DIV;
        end else if (last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_EV_RD;
        end
      end
      S_EV_DIV: begin
        if (div_rsp.done) begin
          total_nxt = total_r + mq_pkg::QUAL_BITS'(div_rsp.quo);
          if (last) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_EV_RD;
          end
        end
      end
      S_DONE: begin
        // wait for the output register, then drop every accumulator
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_quality_nxt = total_r;
          vld_nxt         = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // label memory: written on label words, read at row and column
  always_ff @(posedge clk) begin
    if (acc_in && (in_opcode == mq_pkg::OP_LABEL)) begin
      label_mem[in_row_node] <= in_cluster_label[CB-1:0] - 1'b1;
    end
    lab0_r <= label_mem[in_row_node];
    lab1_r <= label_mem[in_col_node];
  end

  // accumulator memories: two read ports, one write port
  always_ff @(posedge clk) begin
    if (acc_we) begin
      intra_mem[acc_waddr] <= intra_wdata;
      all_mem[acc_waddr]   <= all_wdata;
    end
    intra0_r <= intra_mem[acc_addr0];
    all0_r   <= all_mem[acc_addr0];
    intra1_r <= intra_mem[lab1_r];
    all1_r   <= all_mem[lab1_r];
  end

  always_ff @(posedge clk) begin
    rc_r          <= rc_nxt;
    cc_r          <= cc_nxt;
    w_r           <= w_nxt;
    cnt_r         <= cnt_nxt;
    intra_cc_r    <= intra_cc_nxt;
    all_cc_r      <= all_cc_nxt;
    total_r       <= total_nxt;
    out_quality_r <= out_quality_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_quality = out_quality_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");

  a_div_place: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_EV_DIV))
    else $error("divider finished outside evaluate");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || !out_stall)) |=> (vld_r == '0))
    else $error("accumulators not cleared after evaluate");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r <= mq_pkg::QUAL_BITS'(1 << 24)) || (state_r == S_IDLE))
    else $error("quality total beyond cluster count");

endmodule
